// ----- src/vlfs_pkg.sv -----
// shared types, constants and helpers for the variable length frame stack
package vlfs_pkg;

  // default sizes of the frame memory
  localparam int MEM_DEPTH_DEF = 1024;
  localparam int WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 10;
  localparam int LEN_W  = 10;
  localparam int CAP_W  = 11;
  localparam int SIZE_W = 11;
  localparam int PTR_W  = 11;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(1024);
  localparam logic [SIZE_W-1:0] MAX_ELEM  = SIZE_W'(1023);

  // transaction commands, any code other than push and pop acts as a read
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_READ = 2'd2
  } cmd_code_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_CAP   = 2'd2,
    ST_IDX   = 2'd3
  } stat_code_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic hdr_phase;
    logic cap_phase;
    logic out_from_res;
    logic out_from_hold;
    logic hold_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_hdr;
    logic need_rd;
  } dp_stat_t;

  // data words of a frame, zero for the bottom marker
  function automatic logic [LEN_W-1:0] top_len(input logic [SIZE_W-1:0] s);
    return (s == '0) ? '0 : LEN_W'(s - SIZE_W'(1));
  endfunction

endpackage

// ----- src/vlfs_ram.sv -----
// generic single port ram with registered read
module vlfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/vlfs_ctrl.sv -----
// controller state machine of the variable length frame stack
module vlfs_ctrl import vlfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HDR  = 4'b0010,
    S_RDW  = 4'b0100,
    S_DLV  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   fin;

  assign out_free = !out_valid_r || !out_stall;

  // next state and datapath commands
  always_comb begin
    cmd       = '0;
    fin       = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.need_hdr) begin
            state_nxt = S_HDR;
          end else if (stat.need_rd) begin
            state_nxt = S_RDW;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_HDR: begin
        cmd.hdr_phase = 1'b1;
        fin           = 1'b1;
      end
      S_RDW: begin
        cmd.cap_phase = 1'b1;
        fin           = 1'b1;
      end
      S_DLV: begin
        if (out_free) begin
          cmd.out_from_hold = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // result ready: straight to the output register or park it
    if (fin) begin
      if (out_free) begin
        cmd.out_from_res = 1'b1;
        state_nxt        = S_IDLE;
      end else begin
        cmd.hold_load = 1'b1;
        state_nxt     = S_DLV;
      end
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = (out_valid_r && out_stall) || cmd.out_from_res || cmd.out_from_hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/vlfs_dp.sv -----
// datapath of the variable length frame stack: pointers, frame memory, results
module vlfs_dp import vlfs_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  logic                 in_last_word,
  input  logic [IDX_W-1:0]     in_word_index,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [STAT_W-1:0]    out_status,
  output logic [WORD_BITS-1:0] out_read_word,
  output logic [LEN_W-1:0]     out_top_length
);

  localparam int AW       = $clog2(MEM_DEPTH);
  localparam int MEM_BITS = (WORD_BITS > SIZE_W) ? WORD_BITS : SIZE_W;
  localparam int SUM_W    = PTR_W + 2;

  // architectural state
  logic [CAP_W-1:0]  cap_r, cap_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [SIZE_W-1:0] tfs_r, tfs_nxt;
  logic [LEN_W-1:0]  bc_r, bc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              pop_r, pop_nxt;

  // result registers
  logic [STAT_W-1:0]    hold_status_r;
  logic [WORD_BITS-1:0] hold_word_r;
  logic [LEN_W-1:0]     hold_len_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic [LEN_W-1:0]     out_len_r;

  logic                is_push, is_pop;
  logic [CAP_W-1:0]    lim;
  logic [SIZE_W-1:0]   k, fsize;
  logic                room, fits, commit, empty, idx_bad;
  logic [LEN_W-1:0]    cur_len;
  logic [PTR_W-1:0]    pop_head;
  logic [PTR_W:0]      rd_addr;
  logic [STAT_W-1:0]   acc_status;
  logic [STAT_W-1:0]   res_status;
  logic [WORD_BITS-1:0] res_word;
  logic [LEN_W-1:0]    res_len;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [MEM_BITS-1:0] ram_wdata, ram_rdata;

  // command decode and bounds
  assign is_push  = (in_command == CMD_PUSH);
  assign is_pop   = (in_command == CMD_POP);
  assign lim      = (int'(cap_r) < MEM_DEPTH) ? cap_r : CAP_W'(MEM_DEPTH);
  assign k        = SIZE_W'(bc_r) + SIZE_W'(1);
  assign fsize    = k + SIZE_W'(1);
  assign room     = (SUM_W'(head_r) + SUM_W'(2) + SUM_W'(k)) <= SUM_W'(lim);
  assign fits     = !ovf_r && (k <= MAX_ELEM) && room;
  assign commit   = fits && in_last_word;
  assign empty    = (tfs_r == '0);
  assign cur_len  = top_len(tfs_r);
  assign idx_bad  = (in_word_index >= cur_len);
  assign pop_head = (tfs_r <= head_r) ? (head_r - tfs_r) : '0;
  assign rd_addr  = (PTR_W+1)'(head_r) - (PTR_W+1)'(tfs_r) + (PTR_W+1)'(1)
                  + (PTR_W+1)'(in_word_index);

  // status of the transaction being accepted
  always_comb begin
    if (is_push) begin
      acc_status = fits ? ST_OK : ST_CAP;
    end else if (empty) begin
      acc_status = ST_EMPTY;
    end else if (!is_pop && idx_bad) begin
      acc_status = ST_IDX;
    end else begin
      acc_status = ST_OK;
    end
  end

  assign stat.need_hdr = is_push && commit;
  assign stat.need_rd  = (is_pop && !empty && (pop_head != '0))
                       || (!is_push && !is_pop && !empty && !idx_bad);

  // state updates
  always_comb begin
    cap_nxt  = cfg_wr_en ? cfg_wr_data : cap_r;
    head_nxt = head_r;
    tfs_nxt  = tfs_r;
    bc_nxt   = bc_r;
    ovf_nxt  = ovf_r;
    pop_nxt  = pop_r;
    if (cmd.accept) begin
      pop_nxt = is_pop;
      if (is_push) begin
        if (fits) begin
          bc_nxt = LEN_W'(k);
        end else begin
          ovf_nxt = 1'b1;
        end
        if (commit) begin
          head_nxt = head_r + PTR_W'(fsize);
          tfs_nxt  = fsize;
        end
        if (in_last_word) begin
          bc_nxt  = '0;
          ovf_nxt = 1'b0;
        end
      end else begin
        // pop or read discards a partial element
        bc_nxt  = '0;
        ovf_nxt = 1'b0;
        if (is_pop && !empty) begin
          head_nxt = pop_head;
          if (pop_head == '0) begin
            tfs_nxt = '0;
          end
        end
      end
    end
    // pop picks up the back-link of the new head
    if (cmd.cap_phase && pop_r) begin
      tfs_nxt = ram_rdata[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      tfs_r  <= '0;
      bc_r   <= '0;
      ovf_r  <= 1'b0;
      pop_r  <= 1'b0;
    end else begin
      cap_r  <= cap_nxt;
      head_r <= head_nxt;
      tfs_r  <= tfs_nxt;
      bc_r   <= bc_nxt;
      ovf_r  <= ovf_nxt;
      pop_r  <= pop_nxt;
    end
  end

  // memory port: data word, header, or read address
  always_comb begin
    ram_we    = (cmd.accept && is_push && fits) || cmd.hdr_phase;
    ram_wdata = cmd.hdr_phase ? MEM_BITS'(tfs_r) : MEM_BITS'(in_data_word);
    priority if (cmd.hdr_phase) begin
      ram_addr = AW'(head_r);
    end else if (is_push) begin
      ram_addr = AW'(head_r + PTR_W'(k));
    end else if (is_pop) begin
      ram_addr = AW'(pop_head);
    end else begin
      ram_addr = AW'(rd_addr);
    end
  end

  vlfs_ram #(
    .WIDTH (MEM_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result of the finishing transaction
  assign res_len    = top_len(tfs_nxt);
  assign res_status = cmd.accept ? acc_status : ST_OK;
  assign res_word   = (cmd.cap_phase && !pop_r) ? ram_rdata[WORD_BITS-1:0] : '0;

  // hold stage and output register
  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_status_r <= res_status;
      hold_word_r   <= res_word;
      hold_len_r    <= res_len;
    end
    if (cmd.out_from_res) begin
      out_status_r <= res_status;
      out_word_r   <= res_word;
      out_len_r    <= res_len;
    end else if (cmd.out_from_hold) begin
      out_status_r <= hold_status_r;
      out_word_r   <= hold_word_r;
      out_len_r    <= hold_len_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_read_word  = out_word_r;
  assign out_top_length = out_len_r;

endmodule

// ----- src/variable_length_frame_stack_core.sv -----
// Variable length frame stack: a LIFO of variable length elements in one
// single port word memory with registered read. A push data word that is not
// the last one finishes on acceptance; the last word of a fitting element also
// passes a header state, since the header above the new top goes through the
// same memory port. A pop passes a read-wait state (not on an empty stack or
// when it reaches the bottom), because the back-link of the new head must come
// out of the registered memory read; so does a read, unless it reports empty
// or a bad index. One result is held in the output register and a second in a
// hold stage, so one more transaction is taken while a result waits to be drained; the input then stalls.
// No clearing pass runs after reset: the bottom header is never stored and is
// recognized by the head reaching address zero.
module variable_length_frame_stack_core import vlfs_pkg::*; #(
  parameter int MEM_DEPTH = MEM_DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CAP_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [WORD_BITS-1:0] in_data_word,
  input  logic                 in_last_word,
  input  logic [IDX_W-1:0]     in_word_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [WORD_BITS-1:0] out_read_word,
  output logic [LEN_W-1:0]     out_top_length
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing
  vlfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pointers, memory and results
  vlfs_dp #(
    .MEM_DEPTH (MEM_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_command),
    .in_data_word   (in_data_word),
    .in_last_word   (in_last_word),
    .in_word_index  (in_word_index),
    .cmd            (cmd),
    .stat           (stat),
    .out_status     (out_status),
    .out_read_word  (out_read_word),
    .out_top_length (out_top_length)
  );

endmodule

// ----- src/vlfs_checker.sv -----
// port level checks of the frame stack and their bind to the top level
module vlfs_checker import vlfs_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [STAT_W-1:0]    out_status,
  input logic [WORD_BITS-1:0] out_read_word,
  input logic [LEN_W-1:0]     out_top_length
);

  // a stalled result transaction stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result transaction keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_read_word)
                               && $stable(out_top_length))
    else $error("result payload changed while stalled");

  // an empty stack has no top element
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_top_length == '0))
    else $error("empty status with nonzero length");

  // only a successful read returns data
  a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_word != '0) |-> (out_status == ST_OK))
    else $error("read word on failed transaction");

  // a bad index is only reported against a real element
  a_idx_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_IDX) |-> (out_top_length != '0))
    else $error("index error on empty element");

endmodule

bind variable_length_frame_stack_core vlfs_checker #(
  .WORD_BITS (WORD_BITS)
) u_vlfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_read_word  (out_read_word),
  .out_top_length (out_top_length)
);

// ----- test/tb_variable_length_frame_stack_core.sv -----
// self-checking testbench for the variable length frame stack core
`timescale 1ns / 1ps

module tb_variable_length_frame_stack_core import vlfs_pkg::*;;

  localparam int WORD_W = WORD_BITS_DEF;
  localparam int LONGEST_ELEMENT = 1023;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unnamed code, acts as a read
  localparam logic [CAP_W-1:0] NO_CAP_WRITE = '0;
  localparam int PROBE_ROWS = 28;
  localparam int PHASES = 6;

  // one result of the block
  typedef struct packed {
    stat_code_t        status;
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  length;
  } stack_reply_t;

  // one row of the directed probe table
  typedef struct packed {
    logic [CAP_W-1:0]  cap_first;
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] data;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic              typed;
    stack_reply_t      reply;
  } probe_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_command;
  logic [WORD_W-1:0]    in_data_word;
  logic                 in_last_word;
  logic [IDX_W-1:0]     in_word_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    out_status;
  logic [WORD_W-1:0]    out_read_word;
  logic [LEN_W-1:0]     out_top_length;

  // typed expectation riding along with the current transaction
  logic         row_typed;
  stack_reply_t row_reply;

  // shadow copy of the stack state
  logic [WORD_W-1:0] sh_mem [0:MEM_DEPTH_DEF-1];
  logic [PTR_W-1:0]  sh_head;
  logic [SIZE_W-1:0] sh_top;
  logic [LEN_W-1:0]  sh_build;
  logic              sh_over;
  logic [CAP_W-1:0]  sh_cap;

  stack_reply_t replies_due [$];
  int error_count;
  int items_sent;
  bit send_steady;
  bit recv_steady;

  probe_row_t probe_rows [0:PROBE_ROWS-1] = '{
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_EMPTY, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_EMPTY, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'hFFFFFFFF, 1'b0, 10'h3FF, 1'b1, '{ST_OK, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'h0, 1'b1, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd2}},
    '{NO_CAP_WRITE, CMD_READ, 32'hFFFFFFFF, 1'b1, 10'd1, 1'b1, '{ST_OK, 32'h0, 10'd2}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 10'd2}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'h3FF, 1'b1, '{ST_IDX, 32'h0, 10'd2}},
    '{NO_CAP_WRITE, CMD_SPARE, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'hFFFFFFFF, 10'd2}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'hA5A5A5A5, 1'b1, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'h1, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'hA5A5A5A5, 10'd1}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'h2, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd2}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_EMPTY, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'h5A5A5A5A, 1'b1, 10'h3FF, 1'b1, '{ST_OK, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'h3FF, 1'b1, '{ST_IDX, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd0}},
    '{11'd2, CMD_PUSH, 32'h7, 1'b0, 10'd0, 1'b1, '{ST_CAP, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'h8, 1'b1, 10'd0, 1'b1, '{ST_CAP, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_EMPTY, 32'h0, 10'd0}},
    '{11'd4, CMD_PUSH, 32'h9, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'hA, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'hB, 1'b1, 10'd0, 1'b1, '{ST_CAP, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_PUSH, 32'hC, 1'b1, 10'd0, 1'b0, '{ST_OK, 32'h0, 10'd0}},
    '{11'd2, CMD_PUSH, 32'hD, 1'b1, 10'd0, 1'b1, '{ST_CAP, 32'h0, 10'd1}},
    '{NO_CAP_WRITE, CMD_READ, 32'h0, 1'b0, 10'd0, 1'b0, '{ST_OK, 32'h0, 10'd0}},
    '{NO_CAP_WRITE, CMD_POP, 32'h0, 1'b0, 10'd0, 1'b1, '{ST_OK, 32'h0, 10'd0}}
  };

  logic [CAP_W-1:0] phase_caps [0:PHASES-1] = '{11'd1024, 11'd2, 11'd3, 11'd9, 11'd40, 11'd300};
  int phase_ends [0:PHASES-1] = '{1150, 1260, 1370, 1480, 1590, 1700};

  variable_length_frame_stack_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_data_word  (in_data_word),
    .in_last_word  (in_last_word),
    .in_word_index (in_word_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_word (out_read_word),
    .out_top_length(out_top_length)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // data words of the shadow top element
  function automatic logic [LEN_W-1:0] shadow_len();
    return (sh_top == '0) ? '0 : LEN_W'(sh_top - SIZE_W'(1));
  endfunction

  // advance the shadow stack by one transaction and give its result
  task automatic shadow_stack_step(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] data,
                                   input logic last, input logic [IDX_W-1:0] idx,
                                   output stack_reply_t r);
    int k;
    int fit_limit;
    int fsize;
    int base;
    r.status = ST_OK;
    r.word = '0;
    fit_limit = (sh_cap < MEM_DEPTH_DEF) ? int'(sh_cap) : MEM_DEPTH_DEF;
    if (cmd == CMD_PUSH) begin
      // append a word, commit on the last one unless it stopped fitting
      if (!sh_over) begin
        k = sh_build + 1;
        if (k > LONGEST_ELEMENT || sh_head + 2 + k > fit_limit) begin
          sh_over = 1'b1;
        end else begin
          sh_mem[(sh_head + k) % MEM_DEPTH_DEF] = data;
          sh_build = LEN_W'(k);
        end
      end
      if (sh_over) begin
        r.status = ST_CAP;
      end else if (last) begin
        fsize = sh_build + 1;
        sh_head = PTR_W'(sh_head + fsize);
        sh_mem[sh_head % MEM_DEPTH_DEF] = fsize;
        sh_top = SIZE_W'(fsize);
      end
      if (last) begin
        sh_build = '0;
        sh_over = 1'b0;
      end
    end else if (cmd == CMD_POP) begin
      // partial element is discarded, then follow the back-link
      sh_build = '0;
      sh_over = 1'b0;
      if (sh_top == '0) begin
        r.status = ST_EMPTY;
      end else begin
        sh_head = (sh_top <= sh_head) ? PTR_W'(sh_head - sh_top) : '0;
        sh_top = SIZE_W'(sh_mem[sh_head % MEM_DEPTH_DEF]);
      end
    end else begin
      // read, including the spare code
      sh_build = '0;
      sh_over = 1'b0;
      if (sh_top == '0) begin
        r.status = ST_EMPTY;
      end else if (idx >= shadow_len()) begin
        r.status = ST_IDX;
      end else begin
        base = sh_head - sh_top + 1;
        r.word = sh_mem[(base + idx) % MEM_DEPTH_DEF];
      end
    end
    r.length = shadow_len();
  endtask

  // scoreboard: predict on accepted inputs, check accepted results
  always @(posedge clk) begin : scoreboard
    stack_reply_t got_pred;
    stack_reply_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        shadow_stack_step(in_command, in_data_word, in_last_word, in_word_index, got_pred);
        if (row_typed) got_pred = row_reply;
        replies_due.push_back(got_pred);
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          flag_error("result with no transaction outstanding");
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status)
            flag_error($sformatf("status %0d, expected %0d", out_status, want.status));
          if (out_read_word !== want.word)
            flag_error($sformatf("read_word %h, expected %h", out_read_word, want.word));
          if (out_top_length !== want.length)
            flag_error($sformatf("top_length %0d, expected %0d", out_top_length, want.length));
        end
      end
    end
  end

  function automatic int sender_gap();
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    return send_steady ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic int receiver_gap();
    if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
    return recv_steady ? 0 : $urandom_range(0, 10);
  endfunction

  // result side: random stall before each transaction
  initial begin : drain_results
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      n = receiver_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // offer one transaction and wait until it is taken; returns at a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] data,
                           input logic last, input logic [IDX_W-1:0] idx,
                           input logic typed = 1'b0, input stack_reply_t want = '0);
    int n;
    n = sender_gap();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_word <= data;
    in_last_word <= last;
    in_word_index <= idx;
    row_typed <= typed;
    row_reply <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sh_cap = value;
  endtask

  // stimulus
  initial begin : stimulus
    int len;
    int cut;
    int pick;
    int p;
    logic [CMD_W-1:0] rd_cmd;
    logic [IDX_W-1:0] rd_idx;

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_command = CMD_PUSH;
    in_data_word = '0;
    in_last_word = 1'b0;
    in_word_index = '0;
    row_typed = 1'b0;
    row_reply = '0;
    error_count = 0;
    items_sent = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    for (int i = 0; i < MEM_DEPTH_DEF; i++) sh_mem[i] = '0;
    sh_head = '0;
    sh_top = '0;
    sh_build = '0;
    sh_over = 1'b0;
    sh_cap = CAP_RESET;

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed probe table
    for (int i = 0; i < PROBE_ROWS; i++) begin
      if (probe_rows[i].cap_first != NO_CAP_WRITE) write_capacity(probe_rows[i].cap_first);
      send_item(probe_rows[i].cmd, probe_rows[i].data, probe_rows[i].last, probe_rows[i].idx,
                probe_rows[i].typed, probe_rows[i].reply);
    end

    // random phases, one capacity setting each
    for (p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      if (p == 0) begin
        // largest element that fits, reads across it, then an overflowing push
        while (sh_top != '0)
          send_item(CMD_POP, $urandom, 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 1023)));
        for (int i = 1; i <= MEM_DEPTH_DEF - 2; i++)
          send_item(CMD_PUSH, $urandom, i == MEM_DEPTH_DEF - 2,
                    IDX_W'($urandom_range(0, 1023)));
        for (int i = 0; i < 24; i++)
          send_item(CMD_READ, $urandom, 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 1021)));
        send_item(CMD_PUSH, $urandom, 1'b1, IDX_W'($urandom_range(0, 1023)));
        send_item(CMD_POP, $urandom, 1'($urandom_range(0, 1)),
                  IDX_W'($urandom_range(0, 1023)));
      end
      while (items_sent < phase_ends[p]) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // element of random size, now and then cut short by a pop or read
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
          cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : len + 1;
          for (int i = 1; i <= len && i < cut; i++)
            send_item(CMD_PUSH, $urandom, i == len, IDX_W'($urandom_range(0, 1023)));
          if (cut <= len)
            send_item($urandom_range(0, 1) ? CMD_POP : CMD_READ, $urandom,
                      1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 1023)));
        end else if (pick < 75) begin
          rd_cmd = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_READ;
          if (shadow_len() != 0 && $urandom_range(0, 4) != 0)
            rd_idx = IDX_W'($urandom_range(0, shadow_len() - 1));
          else
            rd_idx = IDX_W'($urandom_range(0, 1023));
          send_item(rd_cmd, $urandom, 1'($urandom_range(0, 1)), rd_idx);
        end else if (pick < 90) begin
          send_item(CMD_POP, $urandom, 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 1023)));
        end else begin
          send_item(CMD_W'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                    IDX_W'($urandom_range(0, 1023)));
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    // let everything drain, then allow for stray results
    wait_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- sim.f -----
src/vlfs_pkg.sv
src/vlfs_ram.sv
src/vlfs_ctrl.sv
src/vlfs_dp.sv
src/variable_length_frame_stack_core.sv
src/vlfs_checker.sv
test/tb_variable_length_frame_stack_core.sv
